// ===== src/cpdc_pkg.sv =====
// ----------------------------------------------------------------------------
// cpdc_pkg
// Shared widths, channel word types and sequencer states of the common prime divisor check.
// ----------------------------------------------------------------------------
package cpdc_pkg;
  localparam int VALUE_WIDTH = 31;
  localparam int COUNT_WIDTH = 16;
  localparam int SHIFT_WIDTH = $clog2(VALUE_WIDTH + 1);

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef struct packed {
    value_t value_a;
    value_t value_b;
    logic   start_set;
  } in_word_t;

  typedef struct packed {
    logic   same_primes;
    count_t match_total;
    logic   bad_input;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GCD_TWOS,
    ST_GCD_XODD,
    ST_GCD_LOOP,
    ST_RED_CHECK,
    ST_DIV_INIT,
    ST_DIV_STEP,
    ST_DONE,
    ST_OUT
  } state_t;
endpackage

// ===== src/cpdc_if.sv =====
// ----------------------------------------------------------------------------
// cpdc_if
// Valid/ready channel carrying one word of type word_t.
// ----------------------------------------------------------------------------
interface cpdc_if #(parameter type word_t = logic) (input logic clk);
  logic  valid;
  logic  ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/common_prime_divisor_check_unit.sv =====
// ----------------------------------------------------------------------------
// common_prime_divisor_check_unit
// Decides whether two values have the same prime divisor set.
// ----------------------------------------------------------------------------
// A zero operand goes from idle straight to the done and output states; else the run
// is data dependent: each reduction round is a binary GCD (one shift or subtract per
// cycle) plus a restoring divide, at most 30 rounds per value.
// One word at a time; in.ready is high only while idle with no result
// pending. A new word is taken once the result word in the output register goes.
// Reset (synchronous, rst) clears the sequencer, output valid and match count.
module common_prime_divisor_check_unit (
  input logic clk,
  input logic rst,
  cpdc_if.sink   in,
  cpdc_if.source out
);
  import cpdc_pkg::*;

  state_t state, state_next;
  value_t a_reg, b_reg, gx, gy, g_reg, work_value, d_reg, quo, rem;
  logic [SHIFT_WIDTH-1:0] twos, bitcnt;
  logic   phase_b;   // 0: reducing a, 1: reducing b
  logic   gcd_red;   // GCD run belongs to reduction
  count_t match_count;
  logic   ovalid;
  logic   accept;
  logic   in_zero;
  out_word_t oword;
  localparam count_t CNT_MAX = '1;
  localparam value_t ONE = value_t'(1);

  assign in.ready  = (state == ST_IDLE) && !ovalid;
  assign out.valid = ovalid;
  assign out.data  = oword;
  assign accept    = in.valid && in.ready;
  assign in_zero   = (in.data.value_a == '0) || (in.data.value_b == '0);

  // Restoring divide step
  logic [VALUE_WIDTH:0] trial;
  assign trial = {rem, quo[VALUE_WIDTH-1]} - {1'b0, d_reg};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (accept) state_next = in_zero ? ST_DONE : ST_GCD_TWOS;
      ST_GCD_TWOS: if (gx[0] | gy[0]) state_next = ST_GCD_XODD;
      ST_GCD_XODD: if (gx[0]) state_next = ST_GCD_LOOP;
      ST_GCD_LOOP: if (gy == '0) state_next = gcd_red ? ST_DIV_INIT : ST_RED_CHECK;
      ST_RED_CHECK: begin
        if (work_value == ONE) state_next = phase_b ? ST_DONE : ST_RED_CHECK;
        else state_next = ST_GCD_TWOS;
      end
      ST_DIV_INIT:  state_next = (d_reg == ONE) ? ST_DONE : ST_DIV_STEP;
      ST_DIV_STEP:  if (bitcnt == SHIFT_WIDTH'(1)) state_next = ST_RED_CHECK;
      ST_DONE:      state_next = ST_OUT;
      ST_OUT:       state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ovalid <= 1'b0;
      match_count <= '0;
    end else begin
      state <= state_next;
      // Raise valid when the result is ready, drop it once taken
      if (state == ST_OUT) ovalid <= 1'b1;
      else if (out.ready) ovalid <= 1'b0;
      unique case (state)
        ST_IDLE: if (accept) begin
          a_reg <= in.data.value_a;
          b_reg <= in.data.value_b;
          gx <= in.data.value_a;
          gy <= in.data.value_b;
          twos <= '0;
          gcd_red <= 1'b0;
          phase_b <= 1'b0;
          if (in.data.start_set) match_count <= '0;
          if (in_zero) begin
            oword.same_primes <= 1'b0;
            oword.bad_input <= 1'b1;
          end else oword.bad_input <= 1'b0;
        end
        // Strip common factors of two
        ST_GCD_TWOS: if (!(gx[0] | gy[0])) begin
          gx <= gx >> 1;
          gy <= gy >> 1;
          twos <= twos + SHIFT_WIDTH'(1);
        end
        ST_GCD_XODD: if (!gx[0]) gx <= gx >> 1;
        // One shift or compare/subtract per cycle
        ST_GCD_LOOP: if (gy != '0) begin
          if (!gy[0]) gy <= gy >> 1;
          else if (gx > gy) begin
            gy <= gx - gy;
            gx <= gy;
          end else gy <= gy - gx;
        end else begin
          if (!gcd_red) begin
            g_reg <= gx << twos;
            work_value <= a_reg;
          end else d_reg <= gx << twos;
        end
        // Decide: value reduced to one (finish, or move on to b), or run the GCD again
        ST_RED_CHECK: begin
          if (work_value == ONE) begin
            if (phase_b) begin
              oword.same_primes <= 1'b1;
              if (match_count != CNT_MAX) match_count <= match_count + count_t'(1);
            end else begin
              phase_b <= 1'b1;
              work_value <= b_reg;
            end
          end else begin
            gx <= work_value;
            gy <= g_reg;
            twos <= '0;
            gcd_red <= 1'b1;
          end
        end
        ST_DIV_INIT: begin
          if (d_reg == ONE) begin
            oword.same_primes <= 1'b0;
          end else begin
            quo <= work_value;
            rem <= '0;
            bitcnt <= SHIFT_WIDTH'(VALUE_WIDTH);
          end
        end
        ST_DIV_STEP: begin
          if (!trial[VALUE_WIDTH]) begin
            rem <= trial[VALUE_WIDTH-1:0];
            quo <= {quo[VALUE_WIDTH-2:0], 1'b1};
          end else begin
            rem <= {rem[VALUE_WIDTH-2:0], quo[VALUE_WIDTH-1]};
            quo <= {quo[VALUE_WIDTH-2:0], 1'b0};
          end
          bitcnt <= bitcnt - SHIFT_WIDTH'(1);
          if (bitcnt == SHIFT_WIDTH'(1)) begin
            work_value <= {quo[VALUE_WIDTH-2:0], ~trial[VALUE_WIDTH]};
            d_reg <= ONE + ONE;
          end
        end
        ST_DONE: oword.match_total <= match_count;
        default: ;
      endcase
    end
  end

  // Accept only while idle
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in.ready |-> state == ST_IDLE) else $error("ready outside idle");
  // Result held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out.valid && !out.ready) |=> (out.valid && $stable(out.data)))
    else $error("result changed while stalled");
  // Bad input never matches
  a_bad: assert property (@(posedge clk) disable iff (rst)
    out.valid |-> !(out.data.bad_input && out.data.same_primes))
    else $error("bad input flagged as match");
endmodule

// ===== dv/tb_common_prime_divisor_check_unit.sv =====
// ----------------------------------------------------------------------------
// tb_common_prime_divisor_check_unit
// Drives value pairs into the prime divisor check and compares each result
// word against a behavioral predictor, with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_common_prime_divisor_check_unit;
  import cpdc_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cpdc_if #(.word_t(in_word_t))  in_ch  (.clk(clk));
  cpdc_if #(.word_t(out_word_t)) out_ch (.clk(clk));

  common_prime_divisor_check_unit u_dut (
    .clk(clk),
    .rst(rst),
    .in (in_ch.sink),
    .out(out_ch.source)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  in_word_t  pair_queue[$];
  out_word_t verdict_queue[$];
  count_t    pred_count;
  int        fail_count;
  int        pairs_sent;
  int        matches_seen;
  int        bad_seen;
  int        idle_cycles;
  bit        stim_done;
  bit        calm;

  // Binary gcd of two nonzero values.
  function automatic logic [63:0] binary_gcd(logic [63:0] x, logic [63:0] y);
    int twos;
    logic [63:0] t;
    twos = 0;
    while (((x | y) & 64'd1) == 0) begin
      x = x >> 1;
      y = y >> 1;
      twos++;
    end
    while (x[0] == 1'b0) x = x >> 1;
    while (y != 0) begin
      while (y[0] == 1'b0) y = y >> 1;
      if (x > y) begin
        t = x;
        x = y;
        y = t;
      end
      y = y - x;
    end
    return x << twos;
  endfunction

  // Strip every prime shared with g; true when 1 remains.
  function automatic bit strips_to_one(logic [63:0] v, logic [63:0] g);
    logic [63:0] d;
    while (v != 1) begin
      d = binary_gcd(v, g);
      if (d == 1) break;
      v = v / d;
    end
    return v == 1;
  endfunction

  // Predict the result word for one pair and advance the count.
  function automatic out_word_t predict_verdict(in_word_t w);
    out_word_t r;
    logic [63:0] g;
    bit bad;
    bit hit;
    bad = (w.value_a == 0) || (w.value_b == 0);
    hit = 1'b0;
    if (w.start_set) pred_count = '0;
    if (!bad) begin
      g = binary_gcd(64'(w.value_a), 64'(w.value_b));
      if (strips_to_one(64'(w.value_a), g)) hit = strips_to_one(64'(w.value_b), g);
    end
    if (hit && pred_count != COUNT_MAX) pred_count = pred_count + 1'b1;
    r.same_primes = hit;
    r.match_total = pred_count;
    r.bad_input   = bad;
    return r;
  endfunction

  function automatic in_word_t make_pair(value_t a, value_t b, logic s);
    in_word_t w;
    w.value_a   = a;
    w.value_b   = b;
    w.start_set = s;
    return w;
  endfunction

  // Random value built from a few small primes, to reach matches often.
  function automatic value_t prime_mix(int sel);
    int primes[6] = '{2, 3, 5, 7, 11, 13};
    logic [63:0] v;
    int k;
    v = 1;
    for (k = 0; k < 6; k++) begin
      if (sel[k]) begin
        v = v * primes[k];
        while ($urandom_range(0, 2) != 0 && v * primes[k] < 64'h7fff_ffff)
          v = v * primes[k];
      end
    end
    if (v == 1) v = 64'd2;
    return value_t'(v);
  endfunction

  // Fill the pair queue: directed corners, then random pairs.
  initial begin
    int n;
    int sel;
    value_t a;
    value_t b;
    pred_count = '0;
    pair_queue.push_back(make_pair(31'd1, 31'd1, 1'b1));
    pair_queue.push_back(make_pair(31'd0, 31'd5, 1'b0));
    pair_queue.push_back(make_pair(31'd7, 31'd0, 1'b0));
    pair_queue.push_back(make_pair(31'd0, 31'd0, 1'b1));
    pair_queue.push_back(make_pair(31'h7fff_ffff, 31'h7fff_ffff, 1'b0));
    pair_queue.push_back(make_pair(31'h7fff_ffff, 31'd1, 1'b0));
    pair_queue.push_back(make_pair(31'd12, 31'd18, 1'b0));
    pair_queue.push_back(make_pair(31'd12, 31'd30, 1'b0));
    pair_queue.push_back(make_pair(31'h4000_0000, 31'd2, 1'b0));
    pair_queue.push_back(make_pair(31'd75, 31'd15, 1'b0));
    pair_queue.push_back(make_pair(31'd2147483646, 31'd6, 1'b0));
    pair_queue.push_back(make_pair(31'd1, 31'd2, 1'b0));
    pair_queue.push_back(make_pair(31'h5555_5555, 31'h2aaa_aaaa, 1'b0));
    pair_queue.push_back(make_pair(31'd2147483629, 31'd2147483629, 1'b1));
    for (n = 0; n < 300; n++) begin
      if ($urandom_range(0, 99) < 65) begin
        sel = $urandom_range(1, 63);
        a = prime_mix(sel);
        b = ($urandom_range(0, 3) == 0) ? prime_mix($urandom_range(1, 63)) : prime_mix(sel);
      end else begin
        a = value_t'($urandom());
        b = value_t'($urandom());
        if ($urandom_range(0, 15) == 0) a = '0;
        if ($urandom_range(0, 15) == 0) b = '0;
      end
      pair_queue.push_back(make_pair(a, b, $urandom_range(0, 39) == 0));
    end
    // Long run of matches to drive the count toward saturation is too slow
    // at 16 bits; saturation stays covered by the predictor path only.
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  // Calm window with no idling on either side.
  always @(posedge clk) begin
    calm <= (pairs_sent >= 120 && pairs_sent < 180);
  end

  // Driver: present the head of the queue, hold until accepted.
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= '0;
      pairs_sent  <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        verdict_queue.push_back(predict_verdict(in_ch.data));
        void'(pair_queue.pop_front());
        pairs_sent <= pairs_sent + 1;
      end
      if ((!in_ch.valid || in_ch.ready) ) begin
        if (in_ch.valid && in_ch.ready) begin
          if (pair_queue.size() > 0 && (calm || $urandom_range(0, 99) >= 22)) begin
            in_ch.valid <= 1'b1;
            in_ch.data  <= pair_queue[0];
          end else begin
            in_ch.valid <= 1'b0;
          end
        end else if (pair_queue.size() > 0 && (calm || $urandom_range(0, 99) >= 22)) begin
          in_ch.valid <= 1'b1;
          in_ch.data  <= pair_queue[0];
        end
      end
    end
  end

  // Monitor: random ready, compare each accepted word.
  always @(posedge clk) begin
    out_word_t exp_w;
    int errs;
    errs = 0;
    if (rst) begin
      out_ch.ready <= 1'b0;
      fail_count   <= 0;
      matches_seen <= 0;
      bad_seen     <= 0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(0, 99) >= 22);
      if (out_ch.valid && out_ch.ready) begin
        if (verdict_queue.size() == 0) begin
          $error("result word with no pending prediction");
          errs++;
        end else begin
          exp_w = verdict_queue.pop_front();
          if (out_ch.data.same_primes !== exp_w.same_primes) begin
            $error("same_primes expected %0d actual %0d", exp_w.same_primes,
                   out_ch.data.same_primes);
            errs++;
          end
          if (out_ch.data.match_total !== exp_w.match_total) begin
            $error("match_total expected %0d actual %0d", exp_w.match_total,
                   out_ch.data.match_total);
            errs++;
          end
          if (out_ch.data.bad_input !== exp_w.bad_input) begin
            $error("bad_input expected %0d actual %0d", exp_w.bad_input,
                   out_ch.data.bad_input);
            errs++;
          end
          if (exp_w.same_primes) matches_seen <= matches_seen + 1;
          if (exp_w.bad_input) bad_seen <= bad_seen + 1;
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
    end
  end

  // Watchdog: count cycles with no accepted word on either channel.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d words pending", verdict_queue.size());
        $display("common_prime_divisor_check_unit regression: fail");
        $finish;
      end
    end
  end

  // End of run: drain, settle, report.
  initial begin
    @(negedge rst);
    wait (pair_queue.size() == 0);
    wait (verdict_queue.size() == 0);
    repeat (2500) @(posedge clk);
    $display("checked %0d pairs: %0d matching, %0d with a zero operand",
             pairs_sent, matches_seen, bad_seen);
    if (fail_count == 0 && verdict_queue.size() == 0) begin
      $display("common_prime_divisor_check_unit regression: pass");
    end else begin
      $display("common_prime_divisor_check_unit regression: fail");
    end
    $finish;
  end
endmodule
